// ===== hdl/wpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpcc_pkg
// Shared types, widths and codes of the weighted point cluster covariance block
// ----------------------------------------------------------------------------
package wpcc_pkg;

    localparam int PosW    = 24;
    localparam int WgtW    = 16;
    localparam int AccW    = 32;
    localparam int CovW    = 48;
    localparam int CovDW   = 47;
    localparam int ModeW   = 2;
    localparam int IdxW    = 3;
    localparam int MulAW   = 48;
    localparam int MulBW   = 34;
    localparam int ProdW   = 80;
    localparam int DvsW    = 34;
    localparam int SumW    = 58;
    localparam int QcapW   = 63;
    localparam int VsumW   = 65;
    localparam int NumAxes = 3;
    localparam int NumCov  = 6;

    typedef logic [ModeW-1:0] t_mode;
    localparam t_mode MODE_ADD    = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_CLEAR  = 2'd2;
    localparam t_mode MODE_HOLD   = 2'd3;

    typedef enum logic [2:0] {
        MUL_MEAN_OLD,
        MUL_MEAN_PT,
        MUL_DIFF,
        MUL_PROD_W,
        MUL_COV_W
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_T2,
        DIV_T1
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MEAN_START,
        ST_MEAN_MO,
        ST_MEAN_MP,
        ST_MEAN_DS,
        ST_MEAN_DIV,
        ST_COV_START,
        ST_COV_D,
        ST_COV_T2M,
        ST_COV_T2D,
        ST_COV_T1M,
        ST_COV_T1D,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic            load;
        logic            clear;
        logic            fault_set;
        logic            fault_val;
        logic            mul_start;
        t_mul_sel        mul_sel;
        logic            acc_load;
        logic            acc_add;
        logic            div_start;
        t_div_sel        div_sel;
        logic            mean_wr;
        logic            psign_wr;
        logic            t2_wr;
        logic            cov_wr;
        logic            cov_zero;
        logic            weight_wr;
        logic            out_load;
        logic [IdxW-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  wnew_pos;
        logic  wold_zero;
        logic  mul_busy;
        logic  div_busy;
    } t_dp_stat;

    // axis pairs of the covariance entries xx, yy, zz, xy, yz, zx
    function automatic logic [1:0] pair_a(input logic [IdxW-1:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0, 3'd3: r = 2'd0;
            3'd1, 3'd4: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [IdxW-1:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0, 3'd5: r = 2'd0;
            3'd1, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/wpcc_if.sv =====
// ----------------------------------------------------------------------------
// wpcc_in_if / wpcc_out_if
// Valid/ready channels for points in and cluster state out
// ----------------------------------------------------------------------------
interface wpcc_in_if;
    logic                              valid;
    logic                              ready;
    logic [wpcc_pkg::ModeW-1:0]        mode;
    logic signed [wpcc_pkg::PosW-1:0]  pos_x;
    logic signed [wpcc_pkg::PosW-1:0]  pos_y;
    logic signed [wpcc_pkg::PosW-1:0]  pos_z;
    logic [wpcc_pkg::WgtW-1:0]         weight;

    modport source (output valid, mode, pos_x, pos_y, pos_z, weight, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, weight, output ready);
endinterface

interface wpcc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wpcc_pkg::PosW-1:0]  mean_x;
    logic signed [wpcc_pkg::PosW-1:0]  mean_y;
    logic signed [wpcc_pkg::PosW-1:0]  mean_z;
    logic [wpcc_pkg::AccW-1:0]         total_weight;
    logic [wpcc_pkg::CovDW-1:0]        cov_xx;
    logic [wpcc_pkg::CovDW-1:0]        cov_yy;
    logic [wpcc_pkg::CovDW-1:0]        cov_zz;
    logic signed [wpcc_pkg::CovW-1:0]  cov_xy;
    logic signed [wpcc_pkg::CovW-1:0]  cov_yz;
    logic signed [wpcc_pkg::CovW-1:0]  cov_zx;
    logic                              weight_fault;

    modport source (output valid, mean_x, mean_y, mean_z, total_weight, cov_xx, cov_yy,
                    cov_zz, cov_xy, cov_yz, cov_zx, weight_fault, input ready);
    modport sink   (input valid, mean_x, mean_y, mean_z, total_weight, cov_xx, cov_yy,
                    cov_zz, cov_xy, cov_yz, cov_zx, weight_fault, output ready);
endinterface

// ===== hdl/weighted_point_cluster_covariance_top.sv =====
// ----------------------------------------------------------------------------
// weighted_point_cluster_covariance_top
// Running weighted mean, total weight and 3x3 covariance of weighted 3D points
// ----------------------------------------------------------------------------
// Every transaction in gives exactly one transaction out carrying the cluster
// state after that point. Points are taken one at a time; a shift-add
// multiplier and a restoring divider are shared by all updates. Clear, the
// unused mode and a non-positive new weight go straight to the output; an add
// or remove onto an empty cluster runs the three mean divisions; an add or
// remove onto a non-empty cluster also runs six covariance entries, three
// multiplies and two divisions each. A finished result sits in an output
// register, so the next point is taken while it waits.
module weighted_point_cluster_covariance_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wpcc_in_if.sink     i_in,
    wpcc_out_if.source  o_out
);

    wpcc_pkg::t_dp_cmd  cmd;
    wpcc_pkg::t_dp_stat stat;

    wpcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    wpcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_in.mode),
        .i_pos_x        (i_in.pos_x),
        .i_pos_y        (i_in.pos_y),
        .i_pos_z        (i_in.pos_z),
        .i_weight       (i_in.weight),
        .o_mean_x       (o_out.mean_x),
        .o_mean_y       (o_out.mean_y),
        .o_mean_z       (o_out.mean_z),
        .o_total_weight (o_out.total_weight),
        .o_cov_xx       (o_out.cov_xx),
        .o_cov_yy       (o_out.cov_yy),
        .o_cov_zz       (o_out.cov_zz),
        .o_cov_xy       (o_out.cov_xy),
        .o_cov_yz       (o_out.cov_yz),
        .o_cov_zx       (o_out.cov_zx),
        .o_weight_fault (o_out.weight_fault)
    );

`ifndef NO_ASSERTIONS
    // one point at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a point is in work");

    // the two iterative units never run together
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.mul_busy && stat.div_busy))
        else $error("multiplier and divider busy at once");

    // a weight fault always reports a cleared cluster
    a_fault_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.weight_fault) |->
            (o_out.total_weight == '0 && o_out.mean_x == '0 && o_out.cov_xx == '0))
        else $error("fault reported with state not cleared");
`endif

endmodule

// ===== hdl/wpcc_dp.sv =====
// ----------------------------------------------------------------------------
// wpcc_dp
// Datapath: cluster state, shift-add multiplier, restoring divider, output reg
// ----------------------------------------------------------------------------
module wpcc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wpcc_pkg::t_dp_cmd                 i_cmd,
    output wpcc_pkg::t_dp_stat                o_stat,
    input  logic [wpcc_pkg::ModeW-1:0]        i_mode,
    input  logic signed [wpcc_pkg::PosW-1:0]  i_pos_x,
    input  logic signed [wpcc_pkg::PosW-1:0]  i_pos_y,
    input  logic signed [wpcc_pkg::PosW-1:0]  i_pos_z,
    input  logic [wpcc_pkg::WgtW-1:0]         i_weight,
    output logic signed [wpcc_pkg::PosW-1:0]  o_mean_x,
    output logic signed [wpcc_pkg::PosW-1:0]  o_mean_y,
    output logic signed [wpcc_pkg::PosW-1:0]  o_mean_z,
    output logic [wpcc_pkg::AccW-1:0]         o_total_weight,
    output logic [wpcc_pkg::CovDW-1:0]        o_cov_xx,
    output logic [wpcc_pkg::CovDW-1:0]        o_cov_yy,
    output logic [wpcc_pkg::CovDW-1:0]        o_cov_zz,
    output logic signed [wpcc_pkg::CovW-1:0]  o_cov_xy,
    output logic signed [wpcc_pkg::CovW-1:0]  o_cov_yz,
    output logic signed [wpcc_pkg::CovW-1:0]  o_cov_zx,
    output logic                              o_weight_fault
);

    localparam int MulCntW = $clog2(wpcc_pkg::MulBW);
    localparam int DivCntW = $clog2(wpcc_pkg::ProdW);
    localparam logic signed [wpcc_pkg::VsumW-1:0] CovHi = 65'sd140737488355327;
    localparam logic signed [wpcc_pkg::VsumW-1:0] CovLo = -65'sd140737488355328;

    // input item and cluster state
    wpcc_pkg::t_mode                   r_mode;
    logic signed [wpcc_pkg::PosW-1:0]  r_p [wpcc_pkg::NumAxes];
    logic [wpcc_pkg::WgtW-1:0]         r_w;
    logic signed [wpcc_pkg::PosW-1:0]  r_m [wpcc_pkg::NumAxes];
    logic [wpcc_pkg::AccW-1:0]         r_wacc;
    logic signed [wpcc_pkg::CovW-1:0]  r_c [wpcc_pkg::NumCov];
    logic                              r_fault;

    // work registers
    logic signed [wpcc_pkg::SumW-1:0]  r_acc;
    logic                              r_psign;
    logic [wpcc_pkg::QcapW-1:0]        r_t2;
    logic                              r_t2neg;

    // multiplier
    logic [wpcc_pkg::MulAW-1:0]        r_mul_a;
    logic [wpcc_pkg::MulAW:0]          r_mul_hi;
    logic [wpcc_pkg::MulBW-1:0]        r_mul_lo;
    logic [MulCntW-1:0]                r_mul_cnt;
    logic                              r_mul_busy;

    // divider
    logic [wpcc_pkg::ProdW-1:0]        r_dq;
    logic [wpcc_pkg::DvsW-1:0]         r_rem;
    logic [wpcc_pkg::DvsW-1:0]         r_dvs;
    logic [DivCntW-1:0]                r_div_cnt;
    logic                              r_div_busy;

    logic                              remove;
    logic signed [wpcc_pkg::WgtW+1:0]  wi;
    logic signed [wpcc_pkg::DvsW-1:0]  wnew;
    logic [wpcc_pkg::DvsW-2:0]         wnew_u;
    logic signed [wpcc_pkg::PosW:0]    d [wpcc_pkg::NumAxes];
    logic signed [wpcc_pkg::PosW-1:0]  m_sel, p_sel;
    logic signed [wpcc_pkg::PosW:0]    da, db;
    logic signed [wpcc_pkg::CovW-1:0]  c_sel;
    logic [wpcc_pkg::PosW-1:0]         m_abs, p_abs;
    logic [wpcc_pkg::PosW:0]           da_abs, db_abs;
    logic [wpcc_pkg::CovW-1:0]         c_abs;
    logic [wpcc_pkg::SumW-1:0]         acc_abs;
    logic [wpcc_pkg::ProdW-1:0]        mul_p;
    logic [wpcc_pkg::SumW-1:0]         p58;
    logic                              s1, s2;
    logic [wpcc_pkg::MulAW-1:0]        op_a;
    logic [wpcc_pkg::MulBW-1:0]        op_b;
    logic [wpcc_pkg::MulAW:0]          mul_sum;
    logic [wpcc_pkg::ProdW-1:0]        half_new, half_old, dvd;
    logic [wpcc_pkg::DvsW-1:0]         dvs;
    logic [wpcc_pkg::DvsW:0]           rem_sh, rem_nx;
    logic                              ge;
    logic                              q_over;
    logic [wpcc_pkg::QcapW-1:0]        qcap;
    logic                              q_ge23, q_gt23;
    logic [wpcc_pkg::PosW-1:0]         mean_new;
    logic signed [wpcc_pkg::VsumW-1:0] t1s, t2s, vsum;
    logic [wpcc_pkg::CovW-1:0]         cov_new;

    always_comb begin
        remove = (r_mode == wpcc_pkg::MODE_REMOVE);
        wi     = remove ? -$signed({2'b00, r_w}) : $signed({2'b00, r_w});
        wnew   = $signed({2'b00, r_wacc}) + wpcc_pkg::DvsW'(wi);
        wnew_u = wnew[wpcc_pkg::DvsW-2:0];
        for (int k = 0; k < wpcc_pkg::NumAxes; k++) begin
            d[k] = {r_m[k][wpcc_pkg::PosW-1], r_m[k]} - {r_p[k][wpcc_pkg::PosW-1], r_p[k]};
        end
        case (i_cmd.idx[1:0])
            2'd1:    begin m_sel = r_m[1]; p_sel = r_p[1]; end
            2'd2:    begin m_sel = r_m[2]; p_sel = r_p[2]; end
            default: begin m_sel = r_m[0]; p_sel = r_p[0]; end
        endcase
        case (wpcc_pkg::pair_a(i_cmd.idx))
            2'd1:    da = d[1];
            2'd2:    da = d[2];
            default: da = d[0];
        endcase
        case (wpcc_pkg::pair_b(i_cmd.idx))
            2'd1:    db = d[1];
            2'd2:    db = d[2];
            default: db = d[0];
        endcase
        case (i_cmd.idx)
            3'd1:    c_sel = r_c[1];
            3'd2:    c_sel = r_c[2];
            3'd3:    c_sel = r_c[3];
            3'd4:    c_sel = r_c[4];
            3'd5:    c_sel = r_c[5];
            default: c_sel = r_c[0];
        endcase
        m_abs   = m_sel[wpcc_pkg::PosW-1] ? (~m_sel + 1'b1) : m_sel;
        p_abs   = p_sel[wpcc_pkg::PosW-1] ? (~p_sel + 1'b1) : p_sel;
        da_abs  = da[wpcc_pkg::PosW] ? (~da + 1'b1) : da;
        db_abs  = db[wpcc_pkg::PosW] ? (~db + 1'b1) : db;
        c_abs   = c_sel[wpcc_pkg::CovW-1] ? (~c_sel + 1'b1) : c_sel;
        acc_abs = r_acc[wpcc_pkg::SumW-1] ? (~r_acc + 1'b1) : r_acc;
        s1      = m_sel[wpcc_pkg::PosW-1];
        s2      = p_sel[wpcc_pkg::PosW-1] ^ remove;
    end

    // multiplier operands
    assign mul_p = {r_mul_hi[wpcc_pkg::ProdW-wpcc_pkg::MulBW-1:0], r_mul_lo};
    assign p58   = {1'b0, mul_p[wpcc_pkg::SumW-2:0]};

    always_comb begin
        case (i_cmd.mul_sel)
            wpcc_pkg::MUL_MEAN_OLD: begin
                op_a = wpcc_pkg::MulAW'(m_abs);
                op_b = wpcc_pkg::MulBW'(r_wacc);
            end
            wpcc_pkg::MUL_MEAN_PT: begin
                op_a = wpcc_pkg::MulAW'(p_abs);
                op_b = wpcc_pkg::MulBW'(r_w);
            end
            wpcc_pkg::MUL_DIFF: begin
                op_a = wpcc_pkg::MulAW'(da_abs);
                op_b = wpcc_pkg::MulBW'(db_abs);
            end
            wpcc_pkg::MUL_PROD_W: begin
                op_a = mul_p[wpcc_pkg::MulAW-1:0];
                op_b = wpcc_pkg::MulBW'(r_w);
            end
            wpcc_pkg::MUL_COV_W: begin
                op_a = c_abs;
                op_b = wpcc_pkg::MulBW'(r_wacc);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mul_sum = r_mul_hi + (r_mul_lo[0] ? {1'b0, r_mul_a} : '0);
    end

    // divider operands and one restoring step
    always_comb begin
        half_new = wpcc_pkg::ProdW'(wnew_u[wpcc_pkg::DvsW-2:1]);
        half_old = wpcc_pkg::ProdW'(r_wacc[wpcc_pkg::AccW-1:1]);
        case (i_cmd.div_sel)
            wpcc_pkg::DIV_T2: begin
                dvd = mul_p + half_old;
                dvs = wpcc_pkg::DvsW'(r_wacc);
            end
            wpcc_pkg::DIV_T1: begin
                dvd = mul_p + half_new;
                dvs = wpcc_pkg::DvsW'(wnew_u);
            end
            default: begin
                dvd = wpcc_pkg::ProdW'(acc_abs) + half_new;
                dvs = wpcc_pkg::DvsW'(wnew_u);
            end
        endcase
        rem_sh = {r_rem, r_dq[wpcc_pkg::ProdW-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // quotient post-processing
    always_comb begin
        q_over = (|r_dq[wpcc_pkg::ProdW-1:wpcc_pkg::QcapW])
               || (r_dq[wpcc_pkg::QcapW-1] && (|r_dq[wpcc_pkg::QcapW-2:0]));
        qcap   = q_over ? {1'b1, {(wpcc_pkg::QcapW-1){1'b0}}} : r_dq[wpcc_pkg::QcapW-1:0];
        q_ge23 = |r_dq[wpcc_pkg::ProdW-1:wpcc_pkg::PosW-1];
        q_gt23 = (|r_dq[wpcc_pkg::ProdW-1:wpcc_pkg::PosW])
               || (r_dq[wpcc_pkg::PosW-1] && (|r_dq[wpcc_pkg::PosW-2:0]));
        if (r_acc[wpcc_pkg::SumW-1]) begin
            mean_new = q_gt23 ? {1'b1, {(wpcc_pkg::PosW-1){1'b0}}}
                              : (~r_dq[wpcc_pkg::PosW-1:0] + 1'b1);
        end else begin
            mean_new = q_ge23 ? {1'b0, {(wpcc_pkg::PosW-1){1'b1}}}
                              : r_dq[wpcc_pkg::PosW-1:0];
        end
        t1s  = c_sel[wpcc_pkg::CovW-1] ? -$signed({2'b00, qcap}) : $signed({2'b00, qcap});
        t2s  = r_t2neg ? -$signed({2'b00, r_t2}) : $signed({2'b00, r_t2});
        vsum = t1s + t2s;
        if (i_cmd.idx < 3'd3) begin
            if (vsum < 0)          cov_new = '0;
            else if (vsum > CovHi) cov_new = CovHi[wpcc_pkg::CovW-1:0];
            else                   cov_new = vsum[wpcc_pkg::CovW-1:0];
        end else begin
            if (vsum > CovHi)      cov_new = CovHi[wpcc_pkg::CovW-1:0];
            else if (vsum < CovLo) cov_new = CovLo[wpcc_pkg::CovW-1:0];
            else                   cov_new = vsum[wpcc_pkg::CovW-1:0];
        end
    end

    // input item and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
            r_w    <= i_weight;
        end
        if (i_cmd.acc_load) begin
            r_acc <= s1 ? -$signed(p58) : $signed(p58);
        end else if (i_cmd.acc_add) begin
            r_acc <= s2 ? (r_acc - $signed(p58)) : (r_acc + $signed(p58));
        end
        if (i_cmd.psign_wr) begin
            r_psign <= da[wpcc_pkg::PosW] ^ db[wpcc_pkg::PosW];
        end
        if (i_cmd.t2_wr) begin
            r_t2    <= qcap;
            r_t2neg <= r_psign ^ remove;
        end
    end

    // cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < wpcc_pkg::NumAxes; k++) r_m[k] <= '0;
            for (int k = 0; k < wpcc_pkg::NumCov; k++) r_c[k] <= '0;
            r_wacc <= '0;
        end else begin
            for (int k = 0; k < wpcc_pkg::NumAxes; k++) begin
                if (i_cmd.mean_wr && i_cmd.idx == wpcc_pkg::IdxW'(k)) r_m[k] <= mean_new;
            end
            for (int k = 0; k < wpcc_pkg::NumCov; k++) begin
                if (i_cmd.cov_zero) begin
                    r_c[k] <= '0;
                end else if (i_cmd.cov_wr && i_cmd.idx == wpcc_pkg::IdxW'(k)) begin
                    r_c[k] <= cov_new;
                end
            end
            if (i_cmd.weight_wr) begin
                r_wacc <= wnew_u[wpcc_pkg::DvsW-2] ? '1 : wnew_u[wpcc_pkg::AccW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
        end else if (i_cmd.fault_set) begin
            r_fault <= i_cmd.fault_val;
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_cnt  <= '0;
        end else if (i_cmd.mul_start) begin
            r_mul_busy <= 1'b1;
            r_mul_cnt  <= '0;
        end else if (r_mul_busy) begin
            r_mul_cnt <= r_mul_cnt + 1'b1;
            if (r_mul_cnt == MulCntW'(wpcc_pkg::MulBW - 1)) r_mul_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mul_a  <= op_a;
            r_mul_hi <= '0;
            r_mul_lo <= op_b;
        end else if (r_mul_busy) begin
            r_mul_hi <= {1'b0, mul_sum[wpcc_pkg::MulAW:1]};
            r_mul_lo <= {mul_sum[0], r_mul_lo[wpcc_pkg::MulBW-1:1]};
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == DivCntW'(wpcc_pkg::ProdW - 1)) r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq  <= dvd;
            r_rem <= '0;
            r_dvs <= dvs;
        end else if (r_div_busy) begin
            r_dq  <= {r_dq[wpcc_pkg::ProdW-2:0], ge};
            r_rem <= rem_nx[wpcc_pkg::DvsW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_mean_x       <= r_m[0];
            o_mean_y       <= r_m[1];
            o_mean_z       <= r_m[2];
            o_total_weight <= r_wacc;
            o_cov_xx       <= r_c[0][wpcc_pkg::CovDW-1:0];
            o_cov_yy       <= r_c[1][wpcc_pkg::CovDW-1:0];
            o_cov_zz       <= r_c[2][wpcc_pkg::CovDW-1:0];
            o_cov_xy       <= r_c[3];
            o_cov_yz       <= r_c[4];
            o_cov_zx       <= r_c[5];
            o_weight_fault <= r_fault;
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.wnew_pos  = !wnew[wpcc_pkg::DvsW-1] && (wnew != '0);
        o_stat.wold_zero = (r_wacc == '0);
        o_stat.mul_busy  = r_mul_busy;
        o_stat.div_busy  = r_div_busy;
    end

endmodule

// ===== hdl/wpcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpcc_ctrl
// Sequencer: steps the mean and covariance updates through the shared units
// ----------------------------------------------------------------------------
module wpcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  wpcc_pkg::t_dp_stat  i_stat,
    output wpcc_pkg::t_dp_cmd   o_cmd
);

    wpcc_pkg::t_state             r_state, n_state;
    logic [wpcc_pkg::IdxW-1:0]    r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wpcc_pkg::ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_in_ready  = (r_state == wpcc_pkg::ST_IDLE);
        unique case (r_state)
            wpcc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wpcc_pkg::ST_DECIDE;
                end
            end
            wpcc_pkg::ST_DECIDE: begin
                o_cmd.fault_set = 1'b1;
                if (i_stat.mode == wpcc_pkg::MODE_CLEAR) begin
                    o_cmd.clear = 1'b1;
                    n_state     = wpcc_pkg::ST_OUT;
                end else if (i_stat.mode == wpcc_pkg::MODE_HOLD) begin
                    n_state = wpcc_pkg::ST_OUT;
                end else if (!i_stat.wnew_pos) begin
                    o_cmd.clear     = 1'b1;
                    o_cmd.fault_val = 1'b1;
                    n_state         = wpcc_pkg::ST_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = wpcc_pkg::ST_MEAN_START;
                end
            end
            wpcc_pkg::ST_MEAN_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = wpcc_pkg::MUL_MEAN_OLD;
                n_state         = wpcc_pkg::ST_MEAN_MO;
            end
            wpcc_pkg::ST_MEAN_MO: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.acc_load  = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = wpcc_pkg::MUL_MEAN_PT;
                    n_state         = wpcc_pkg::ST_MEAN_MP;
                end
            end
            wpcc_pkg::ST_MEAN_MP: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.acc_add = 1'b1;
                    n_state       = wpcc_pkg::ST_MEAN_DS;
                end
            end
            wpcc_pkg::ST_MEAN_DS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wpcc_pkg::DIV_MEAN;
                n_state         = wpcc_pkg::ST_MEAN_DIV;
            end
            wpcc_pkg::ST_MEAN_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.mean_wr = 1'b1;
                    if (r_idx == wpcc_pkg::IdxW'(wpcc_pkg::NumAxes - 1)) begin
                        n_idx = '0;
                        if (i_stat.wold_zero) begin
                            o_cmd.cov_zero  = 1'b1;
                            o_cmd.weight_wr = 1'b1;
                            n_state         = wpcc_pkg::ST_OUT;
                        end else begin
                            n_state = wpcc_pkg::ST_COV_START;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = wpcc_pkg::ST_MEAN_START;
                    end
                end
            end
            wpcc_pkg::ST_COV_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = wpcc_pkg::MUL_DIFF;
                o_cmd.psign_wr  = 1'b1;
                n_state         = wpcc_pkg::ST_COV_D;
            end
            wpcc_pkg::ST_COV_D: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = wpcc_pkg::MUL_PROD_W;
                    n_state         = wpcc_pkg::ST_COV_T2M;
                end
            end
            wpcc_pkg::ST_COV_T2M: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = wpcc_pkg::DIV_T2;
                    n_state         = wpcc_pkg::ST_COV_T2D;
                end
            end
            wpcc_pkg::ST_COV_T2D: begin
                if (!i_stat.div_busy) begin
                    o_cmd.t2_wr     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = wpcc_pkg::MUL_COV_W;
                    n_state         = wpcc_pkg::ST_COV_T1M;
                end
            end
            wpcc_pkg::ST_COV_T1M: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = wpcc_pkg::DIV_T1;
                    n_state         = wpcc_pkg::ST_COV_T1D;
                end
            end
            wpcc_pkg::ST_COV_T1D: begin
                if (!i_stat.div_busy) begin
                    o_cmd.cov_wr = 1'b1;
                    if (r_idx == wpcc_pkg::IdxW'(wpcc_pkg::NumCov - 1)) begin
                        o_cmd.weight_wr = 1'b1;
                        n_idx           = '0;
                        n_state         = wpcc_pkg::ST_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = wpcc_pkg::ST_COV_START;
                    end
                end
            end
            wpcc_pkg::ST_OUT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = wpcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wpcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/sv/weighted_point_cluster_covariance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_point_cluster_covariance_checker
// Watches the point and state channels, predicts the cluster state after every
// accepted point and compares each state transaction field by field
// ----------------------------------------------------------------------------
module weighted_point_cluster_covariance_checker
    import wpcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    wpcc_in_if   i_pt,
    wpcc_out_if  i_st,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam longint MeanMax = 64'sd8388607;
    localparam longint MeanMin = -64'sd8388608;
    localparam longint CovMax  = 64'sd140737488355327;
    localparam longint CovMin  = -64'sd140737488355328;
    localparam logic [63:0] QuotCap = 64'd1 << 62;

    typedef struct {
        logic signed [PosW-1:0]  mean_x;
        logic signed [PosW-1:0]  mean_y;
        logic signed [PosW-1:0]  mean_z;
        logic [AccW-1:0]         total_weight;
        logic [CovDW-1:0]        cov_xx;
        logic [CovDW-1:0]        cov_yy;
        logic [CovDW-1:0]        cov_zz;
        logic signed [CovW-1:0]  cov_xy;
        logic signed [CovW-1:0]  cov_yz;
        logic signed [CovW-1:0]  cov_zx;
        logic                    weight_fault;
    } t_cluster_state;

    longint         mean_pos[NumAxes];
    longint         acc_weight;
    longint         cov_ent[NumCov];
    t_cluster_state state_q[$];

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round(a*b/c) on magnitudes, capped at 2^62
    function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, a} * {64'd0, b} + {64'd0, c >> 1};
        q   = num / {64'd0, c};
        return (q > {64'd0, QuotCap}) ? QuotCap : q[63:0];
    endfunction

    function automatic void clear_cluster();
        foreach (mean_pos[i]) mean_pos[i] = 0;
        foreach (cov_ent[i]) cov_ent[i] = 0;
        acc_weight = 0;
    endfunction

    function automatic t_cluster_state update_cluster(input t_mode m, input longint px,
                                                      input longint py, input longint pz,
                                                      input longint w);
        t_cluster_state s;
        longint pt[NumAxes];
        longint wi, wold, wnew, n, sq, da, db, prod, v;
        logic [63:0] q, t1, t2;
        logic [1:0] a, b;
        logic neg2;
        pt[0] = px; pt[1] = py; pt[2] = pz;
        wi = w;
        s.weight_fault = 1'b0;
        if (m == MODE_CLEAR) begin
            clear_cluster();
        end else if (m == MODE_ADD || m == MODE_REMOVE) begin
            if (m == MODE_REMOVE) wi = -wi;
            wold = acc_weight;
            wnew = wold + wi;
            if (wnew <= 0) begin
                clear_cluster();
                s.weight_fault = 1'b1;
            end else begin
                for (int i = 0; i < NumAxes; i++) begin
                    n  = wold * mean_pos[i] + wi * pt[i];
                    q  = (magnitude(n) + 64'(wnew >>> 1)) / 64'(wnew);
                    sq = (q > (64'd1 << 40)) ? (64'sd1 <<< 40) : longint'(q);
                    mean_pos[i] = clip(n < 0 ? -sq : sq, MeanMin, MeanMax);
                end
                for (int i = 0; i < NumCov; i++) begin
                    v = 0;
                    if (wold != 0) begin
                        a    = pair_a(IdxW'(i));
                        b    = pair_b(IdxW'(i));
                        da   = mean_pos[a] - pt[a];
                        db   = mean_pos[b] - pt[b];
                        prod = da * db;
                        t1   = scaled_quot(magnitude(cov_ent[i]), 64'(wold), 64'(wnew));
                        t2   = scaled_quot(magnitude(prod), magnitude(wi), 64'(wold));
                        neg2 = (prod < 0) != (wi < 0);
                        v    = (cov_ent[i] < 0 ? -longint'(t1) : longint'(t1)) +
                               (neg2 ? -longint'(t2) : longint'(t2));
                    end
                    cov_ent[i] = (i < 3) ? clip(v, 0, CovMax) : clip(v, CovMin, CovMax);
                end
                acc_weight = (wnew > 64'sd4294967295) ? 64'sd4294967295 : wnew;
            end
        end
        s.mean_x       = PosW'(mean_pos[0]);
        s.mean_y       = PosW'(mean_pos[1]);
        s.mean_z       = PosW'(mean_pos[2]);
        s.total_weight = AccW'(acc_weight);
        s.cov_xx       = CovDW'(cov_ent[0]);
        s.cov_yy       = CovDW'(cov_ent[1]);
        s.cov_zz       = CovDW'(cov_ent[2]);
        s.cov_xy       = CovW'(cov_ent[3]);
        s.cov_yz       = CovW'(cov_ent[4]);
        s.cov_zx       = CovW'(cov_ent[5]);
        return s;
    endfunction

    assign o_pending = state_q.size();

    always @(posedge i_clk) begin
        t_cluster_state e;
        if (!i_rst_n) begin
            clear_cluster();
            state_q.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_st.valid && i_st.ready) begin
                if (state_q.size() == 0) begin
                    $error("state transaction with nothing expected");
                    o_fail_cnt++;
                end else begin
                    e = state_q.pop_front();
                    if (i_st.mean_x !== e.mean_x) begin
                        $error("mean_x expected %0d got %0d", e.mean_x, i_st.mean_x);
                        o_fail_cnt++;
                    end
                    if (i_st.mean_y !== e.mean_y) begin
                        $error("mean_y expected %0d got %0d", e.mean_y, i_st.mean_y);
                        o_fail_cnt++;
                    end
                    if (i_st.mean_z !== e.mean_z) begin
                        $error("mean_z expected %0d got %0d", e.mean_z, i_st.mean_z);
                        o_fail_cnt++;
                    end
                    if (i_st.total_weight !== e.total_weight) begin
                        $error("total_weight expected %0d got %0d", e.total_weight,
                               i_st.total_weight);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_xx !== e.cov_xx) begin
                        $error("cov_xx expected %0d got %0d", e.cov_xx, i_st.cov_xx);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_yy !== e.cov_yy) begin
                        $error("cov_yy expected %0d got %0d", e.cov_yy, i_st.cov_yy);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_zz !== e.cov_zz) begin
                        $error("cov_zz expected %0d got %0d", e.cov_zz, i_st.cov_zz);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_xy !== e.cov_xy) begin
                        $error("cov_xy expected %0d got %0d", e.cov_xy, i_st.cov_xy);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_yz !== e.cov_yz) begin
                        $error("cov_yz expected %0d got %0d", e.cov_yz, i_st.cov_yz);
                        o_fail_cnt++;
                    end
                    if (i_st.cov_zx !== e.cov_zx) begin
                        $error("cov_zx expected %0d got %0d", e.cov_zx, i_st.cov_zx);
                        o_fail_cnt++;
                    end
                    if (i_st.weight_fault !== e.weight_fault) begin
                        $error("weight_fault expected %0d got %0d", e.weight_fault,
                               i_st.weight_fault);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_pt.valid && i_pt.ready) begin
                state_q.push_back(update_cluster(t_mode'(i_pt.mode), longint'(i_pt.pos_x),
                                                 longint'(i_pt.pos_y),
                                                 longint'(i_pt.pos_z),
                                                 longint'({1'b0, i_pt.weight})));
            end
        end
    end

endmodule

// ===== tb/sv/weighted_point_cluster_covariance_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_point_cluster_covariance_top_tb
// Drives directed and random weighted points with bursty input and a stalling
// output, and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module weighted_point_cluster_covariance_top_tb;
    import wpcc_pkg::*;

    localparam int NumRandom   = 930;
    localparam int LongHoldLen = 3000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   pending;
    int   accepted  = 0;
    int   burst_left = 0;
    int   hold_left = 0;
    bit   held      = 0;
    int   ready_pct = 100;
    int   phase_cnt = 0;

    wpcc_in_if  pt_ch ();
    wpcc_out_if st_ch ();

    weighted_point_cluster_covariance_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pt_ch),
        .o_out   (st_ch)
    );

    weighted_point_cluster_covariance_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_ch),
        .i_st       (st_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver: phases of changing ready rate, one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            st_ch.ready <= 1'b0;
        end else if (accepted >= 300 && !held) begin
            held = 1;
            hold_left = LongHoldLen;
            st_ch.ready <= 1'b0;
        end else begin
            if (phase_cnt == 0) begin
                phase_cnt = $urandom_range(50, 400);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 30;
                    default: ready_pct = 5;
                endcase
            end
            phase_cnt--;
            st_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    task automatic send_point(input t_mode m, input logic [PosW-1:0] x,
                              input logic [PosW-1:0] y, input logic [PosW-1:0] z,
                              input logic [WgtW-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                pt_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pt_ch.valid  <= 1'b1;
        pt_ch.mode   <= m;
        pt_ch.pos_x  <= x;
        pt_ch.pos_y  <= y;
        pt_ch.pos_z  <= z;
        pt_ch.weight <= w;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        accepted++;
    endtask

    function automatic logic [PosW-1:0] near(input int c, input int spread);
        return PosW'(c + $urandom_range(0, 2 * spread) - spread);
    endfunction

    initial begin
        int cx, cy, cz, spread, left, r;
        t_mode m;
        logic [WgtW-1:0] w;
        pt_ch.valid  = 1'b0;
        pt_ch.mode   = MODE_ADD;
        pt_ch.pos_x  = '0;
        pt_ch.pos_y  = '0;
        pt_ch.pos_z  = '0;
        pt_ch.weight = '0;
        st_ch.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused mode and faults on an empty cluster
        send_point(MODE_HOLD, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 16'hFFFF);
        send_point(MODE_ADD, 24'h000100, 24'h000200, 24'h000300, 16'h0000);
        send_point(MODE_REMOVE, 24'h000100, 24'h000200, 24'h000300, 16'h0005);
        // extreme positions with full weight: saturating covariance
        send_point(MODE_ADD, 24'h7FFFFF, 24'h800000, 24'h000000, 16'hFFFF);
        send_point(MODE_ADD, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 16'hFFFF);
        send_point(MODE_ADD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0001);
        send_point(MODE_REMOVE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0001);
        send_point(MODE_REMOVE, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 16'hFFFF);
        send_point(MODE_REMOVE, 24'h7FFFFF, 24'h800000, 24'h000000, 16'hFFFF);
        send_point(MODE_CLEAR, 24'h123456, 24'hABCDEF, 24'h555555, 16'hAAAA);
        // small values: rounding ties
        send_point(MODE_ADD, 24'h000000, 24'h000000, 24'h000000, 16'h0001);
        send_point(MODE_ADD, 24'h000001, 24'hFFFFFF, 24'h000001, 16'h0001);
        send_point(MODE_ADD, 24'h000003, 24'h000002, 24'hFFFFFD, 16'h0002);
        send_point(MODE_ADD, 24'h400000, 24'hC00000, 24'h000010, 16'h0000);
        send_point(MODE_HOLD, 24'h000000, 24'h000000, 24'h000000, 16'h0000);
        send_point(MODE_REMOVE, 24'h000001, 24'hFFFFFF, 24'h000001, 16'h0000);
        send_point(MODE_REMOVE, 24'h000003, 24'h000002, 24'hFFFFFD, 16'h0001);
        send_point(MODE_ADD, 24'h800000, 24'h800000, 24'h7FFFFF, 16'hFFFF);
        send_point(MODE_ADD, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_point(MODE_REMOVE, 24'h000000, 24'h000000, 24'h000000, 16'hFFFF);
        send_point(MODE_CLEAR, 24'h000000, 24'h000000, 24'h000000, 16'h0000);

        // random clusters: mostly adds around a center, some removes and noise
        left = 0;
        for (int k = 0; k < NumRandom; k++) begin
            if (left == 0) begin
                left   = $urandom_range(5, 40);
                cx     = $urandom_range(0, 4) == 0 ? int'($signed(PosW'($urandom)))
                                                   : $urandom_range(0, 200000) - 100000;
                cy     = $urandom_range(0, 200000) - 100000;
                cz     = $urandom_range(0, 200000) - 100000;
                spread = $urandom_range(0, 3) == 0 ? 8000000 : $urandom_range(1, 5000);
                send_point(MODE_CLEAR, PosW'($urandom), PosW'($urandom), PosW'($urandom),
                           WgtW'($urandom));
            end else begin
                left--;
                r = $urandom_range(1, 100);
                w = $urandom_range(0, 9) == 0 ? WgtW'($urandom)
                                              : WgtW'($urandom_range(1, 1000));
                if (r <= 80) begin
                    send_point(MODE_ADD, near(cx, spread), near(cy, spread),
                               near(cz, spread), w);
                end else if (r <= 90) begin
                    send_point(MODE_REMOVE, near(cx, spread), near(cy, spread),
                               near(cz, spread), WgtW'($urandom_range(0, 300)));
                end else begin
                    m = t_mode'($urandom_range(0, 3));
                    send_point(m, PosW'($urandom), PosW'($urandom), PosW'($urandom),
                               WgtW'($urandom));
                end
            end
        end
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("weighted_point_cluster_covariance_top_tb OK");
        end else begin
            $display("weighted_point_cluster_covariance_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("weighted_point_cluster_covariance_top_tb NOT OK");
        $finish;
    end

endmodule
